[hdl/pldm_pkg.sv]
// Shared widths, codes and beat types for the piecewise linear depth mapper.
// No dependencies; every other file of the block but pldm_ram imports this package.
package pldm_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int MAX_PIECES  = 32;

    localparam int DEPTH_W   = 16;
    localparam int CNT_W     = 6;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = DEPTH_W;
    localparam int K_W       = (MAX_PIECES > 1) ? $clog2(MAX_PIECES) : 1;
    localparam int N_W       = $clog2(MAX_PIECES + 1);
    localparam int PIV_DEPTH = MAX_PIECES + 1;
    localparam int PIV_AW    = $clog2(PIV_DEPTH);
    localparam int X_W       = DEPTH_W + N_W;
    localparam int KD_W      = DEPTH_W + K_W;

    localparam int QS_PER_STG = 4;
    localparam int Q_STG      = (DEPTH_W + QS_PER_STG - 1) / QS_PER_STG;

    localparam int U_W   = DEPTH_W + 2;
    localparam int DP_W  = DEPTH_W + 1;
    localparam int PB_W  = 2 * DEPTH_W + 2;
    localparam int T1_W  = U_W + N_W + 1;
    localparam int T2_W  = T1_W + DP_W;
    localparam int A_W   = T2_W + 2;
    localparam int DD_W  = 2 * DEPTH_W;
    localparam int DEN_W = DD_W + 1;
    localparam int NUM_W = A_W + SAMPLE_BITS;
    localparam int REM_W = DEN_W + SAMPLE_BITS;

    localparam logic [SAMPLE_BITS-1:0] OUT_MAX = '1;

    typedef enum logic {
        OP_MAP   = 1'b0,
        OP_PIVOT = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_DEPTH   = 2'd0,
        CFG_MAX_DEPTH   = 2'd1,
        CFG_PIECE_COUNT = 2'd2,
        CFG_LOW_QUALITY = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [DEPTH_W-1:0] lo;
        logic [DEPTH_W-1:0] d;
        logic [N_W-1:0]     n;
        logic               span_bad;
        logic               low_quality;
    } cfg_t;

    typedef struct packed {
        logic               valid;
        op_t                op;
        logic [CNT_W-1:0]   idx;
        logic [DEPTH_W-1:0] val;
        logic [DEPTH_W-1:0] s;
        logic               neg;
        logic [X_W-1:0]     x;
        logic [K_W-1:0]     k;
    } find_t;

    typedef struct packed {
        logic               valid;
        logic [DEPTH_W-1:0] s;
        logic [KD_W-1:0]    kd;
        logic [DEPTH_W-1:0] p0;
        logic [DEPTH_W-1:0] p1;
    } fetch_t;

    typedef struct packed {
        logic                  valid;
        logic signed [A_W-1:0] a;
        logic [DD_W-1:0]       dd;
    } lin_t;

endpackage

[hdl/pldm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pldm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 33
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic                             re,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/pldm_piece_find.sv]
// Entry stage and bit-per-stage search for the piece index of each sample.
// Depends on pldm_pkg.
module pldm_piece_find
    import pldm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  cfg_t               cfg,
    input  logic               in_valid,
    input  op_t                in_op,
    input  logic [CNT_W-1:0]   in_idx,
    input  logic [DEPTH_W-1:0] in_val,
    input  logic [DEPTH_W-1:0] in_s,
    output find_t              out_beat
);

    find_t              stg_reg  [0:K_W];
    find_t              stg_next [0:K_W];
    logic [DEPTH_W-1:0] diff;

    always_comb
    begin
        diff              = in_s - cfg.lo;
        stg_next[0].valid = in_valid;
        stg_next[0].op    = in_op;
        stg_next[0].idx   = in_idx;
        stg_next[0].val   = in_val;
        stg_next[0].s     = in_s;
        stg_next[0].neg   = (in_s < cfg.lo);
        stg_next[0].x     = X_W'(diff) * X_W'(cfg.n);
        stg_next[0].k     = '0;
    end

    genvar j;
    generate
        for (j = 0; j < K_W; j++)
        begin : g_srch
            logic [K_W-1:0]  cand;
            logic [KD_W-1:0] prod;
            logic            hit;

            always_comb
            begin
                cand = stg_reg[j].k | (K_W'(1) << (K_W - 1 - j));
                prod = KD_W'(cand) * KD_W'(cfg.d);
                hit  = !stg_reg[j].neg && (N_W'(cand) < cfg.n)
                       && (X_W'(prod) <= stg_reg[j].x);
                stg_next[j+1] = stg_reg[j];
                if (hit)
                begin
                    stg_next[j+1].k = cand;
                end
            end
        end

        for (j = 0; j <= K_W; j++)
        begin : g_reg
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    stg_reg[j].valid <= 1'b0;
                end
                else if (adv)
                begin
                    stg_reg[j] <= stg_next[j];
                end
            end
        end
    endgenerate

    assign out_beat = stg_reg[K_W];

endmodule

[hdl/pldm_interp.sv]
// Piece start division and the interpolation products up to the scaled numerator term.
// Depends on pldm_pkg.
module pldm_interp
    import pldm_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   adv,
    input  cfg_t   cfg,
    input  fetch_t in_beat,
    output lin_t   out_beat
);

    typedef struct packed {
        logic               valid;
        logic [DEPTH_W-1:0] s;
        logic [DEPTH_W-1:0] p0;
        logic [DEPTH_W-1:0] p1;
        logic [N_W:0]       rem;
        logic [DEPTH_W-1:0] low;
    } dv_t;

    typedef struct packed {
        logic                   valid;
        logic signed [U_W-1:0]  u;
        logic signed [DP_W-1:0] dp;
        logic signed [PB_W-1:0] pb;
    } us_t;

    typedef struct packed {
        logic                   valid;
        logic signed [T1_W-1:0] t1;
        logic signed [DP_W-1:0] dp;
        logic signed [PB_W-1:0] pb;
    } t1s_t;

    typedef struct packed {
        logic                   valid;
        logic signed [T2_W-1:0] t2;
        logic signed [PB_W-1:0] pb;
    } t2s_t;

    function automatic dv_t div_step(dv_t a, logic [N_W-1:0] n);
        dv_t          r;
        logic [N_W:0] t;
        r = a;
        for (int i = 0; i < QS_PER_STG; i++)
        begin
            t     = {r.rem[N_W-1:0], r.low[DEPTH_W-1]};
            r.low = {r.low[DEPTH_W-2:0], 1'b0};
            if (t >= {1'b0, n})
            begin
                t        = t - {1'b0, n};
                r.low[0] = 1'b1;
            end
            r.rem = t;
        end
        return r;
    endfunction

    dv_t  dv_init;
    dv_t  dv_reg  [0:Q_STG-1];
    dv_t  dv_next [0:Q_STG-1];
    us_t  us_reg, us_next;
    t1s_t t1_reg, t1_next;
    t2s_t t2_reg, t2_next;
    lin_t lin_reg, lin_next;

    always_comb
    begin
        dv_init.valid = in_beat.valid;
        dv_init.s     = in_beat.s;
        dv_init.p0    = in_beat.p0;
        dv_init.p1    = in_beat.p1;
        dv_init.rem   = (N_W+1)'(in_beat.kd[KD_W-1:DEPTH_W]);
        dv_init.low   = in_beat.kd[DEPTH_W-1:0];
        dv_next[0]    = div_step(dv_init, cfg.n);
    end

    genvar j;
    generate
        for (j = 1; j < Q_STG; j++)
        begin : g_div
            always_comb
            begin
                dv_next[j] = div_step(dv_reg[j-1], cfg.n);
            end
        end

        for (j = 0; j < Q_STG; j++)
        begin : g_dreg
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    dv_reg[j].valid <= 1'b0;
                end
                else if (adv)
                begin
                    dv_reg[j] <= dv_next[j];
                end
            end
        end
    endgenerate

    always_comb
    begin
        us_next.valid = dv_reg[Q_STG-1].valid;
        us_next.u     = $signed({2'b00, dv_reg[Q_STG-1].s}) - $signed({2'b00, cfg.lo})
                        - $signed({2'b00, dv_reg[Q_STG-1].low});
        us_next.dp    = $signed({1'b0, dv_reg[Q_STG-1].p1})
                        - $signed({1'b0, dv_reg[Q_STG-1].p0});
        us_next.pb    = $signed({1'b0, cfg.d})
                        * ($signed({1'b0, dv_reg[Q_STG-1].p0}) - $signed({1'b0, cfg.lo}));

        t1_next.valid = us_reg.valid;
        t1_next.t1    = $signed(us_reg.u) * $signed({1'b0, cfg.n});
        t1_next.dp    = us_reg.dp;
        t1_next.pb    = us_reg.pb;

        t2_next.valid = t1_reg.valid;
        t2_next.t2    = $signed(t1_reg.t1) * $signed(t1_reg.dp);
        t2_next.pb    = t1_reg.pb;

        lin_next.valid = t2_reg.valid;
        lin_next.a     = (A_W'($signed(t2_reg.t2)) <<< 1) + (A_W'($signed(t2_reg.pb)) <<< 1)
                         + A_W'($signed({1'b0, cfg.d}));
        lin_next.dd    = DD_W'(cfg.d) * DD_W'(cfg.d);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            us_reg.valid  <= 1'b0;
            t1_reg.valid  <= 1'b0;
            t2_reg.valid  <= 1'b0;
            lin_reg.valid <= 1'b0;
        end
        else if (adv)
        begin
            us_reg  <= us_next;
            t1_reg  <= t1_next;
            t2_reg  <= t2_next;
            lin_reg <= lin_next;
        end
    end

    assign out_beat = lin_reg;

endmodule

[hdl/pldm_scale_div.sv]
// Rescale to output range: restoring division, a quotient bit per stage, clamp, optional halve.
// Depends on pldm_pkg.
module pldm_scale_div
    import pldm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   adv,
    input  cfg_t                   cfg,
    input  lin_t                   in_beat,
    output logic                   res_valid,
    output logic [SAMPLE_BITS-1:0] res_data
);

    typedef struct packed {
        logic             valid;
        logic             neg;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } nm_t;

    typedef struct packed {
        logic                   valid;
        logic                   neg;
        logic                   sat;
        logic [REM_W-1:0]       rem;
        logic [SAMPLE_BITS-1:0] q;
        logic [DEN_W-1:0]       den;
    } qd_t;

    nm_t                    nm_reg, nm_next;
    qd_t                    qd_reg  [0:SAMPLE_BITS];
    qd_t                    qd_next [0:SAMPLE_BITS];
    logic [SAMPLE_BITS-1:0] res;

    always_comb
    begin
        nm_next.valid = in_beat.valid;
        nm_next.neg   = in_beat.a[A_W-1];
        nm_next.num   = {in_beat.a, {SAMPLE_BITS{1'b0}}} - NUM_W'($unsigned(in_beat.a));
        nm_next.den   = {in_beat.dd, 1'b0};

        qd_next[0].valid = nm_reg.valid;
        qd_next[0].neg   = nm_reg.neg;
        qd_next[0].sat   = (nm_reg.num >= NUM_W'({nm_reg.den, {SAMPLE_BITS{1'b0}}}));
        qd_next[0].rem   = nm_reg.num[REM_W-1:0];
        qd_next[0].q     = '0;
        qd_next[0].den   = nm_reg.den;
    end

    genvar j;
    generate
        for (j = 0; j < SAMPLE_BITS; j++)
        begin : g_qbit
            logic [REM_W-1:0] dsh;

            always_comb
            begin
                dsh          = REM_W'(qd_reg[j].den) << (SAMPLE_BITS - 1 - j);
                qd_next[j+1] = qd_reg[j];
                if (qd_reg[j].rem >= dsh)
                begin
                    qd_next[j+1].rem                   = qd_reg[j].rem - dsh;
                    qd_next[j+1].q[SAMPLE_BITS - 1 - j] = 1'b1;
                end
            end
        end

        for (j = 0; j <= SAMPLE_BITS; j++)
        begin : g_qreg
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    qd_reg[j].valid <= 1'b0;
                end
                else if (adv)
                begin
                    qd_reg[j] <= qd_next[j];
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nm_reg.valid <= 1'b0;
        end
        else if (adv)
        begin
            nm_reg <= nm_next;
        end
    end

    always_comb
    begin
        priority if (cfg.span_bad || qd_reg[SAMPLE_BITS].neg)
        begin
            res = '0;
        end
        else if (qd_reg[SAMPLE_BITS].sat)
        begin
            res = OUT_MAX;
        end
        else
        begin
            res = qd_reg[SAMPLE_BITS].q;
        end
        if (cfg.low_quality)
        begin
            res = res >> 1;
        end
    end

    assign res_valid = qd_reg[SAMPLE_BITS].valid;
    assign res_data  = res;

endmodule

[hdl/piecewise_linear_depth_mapper_top.sv]
// Top level of the piecewise linear depth mapper: config registers, pivot RAMs, pipeline.
// Depends on pldm_pkg, pldm_ram, pldm_piece_find, pldm_interp and pldm_scale_div.
//
//   channel  direction  handshake              payload
//   cfg      in         cfg_write              cfg_index, cfg_data
//   in       in         in_valid / in_stall    operation, pivot_index, pivot_value, sample
//   out      out        out_valid / out_stall  mapped_sample
//
// One beat per cycle in while in_stall is low; a mapped sample passes the entry register,
// 5-stage piece search, fetch, 4-stage piece start division, products, 16-stage rescale, output.
// Pivot writes land in the RAMs at the fetch stage, in order with the samples.
// Reset clears the valid bits and the settings; the pivot table has no clearing pass.
// in_stall rises only when the last stage holds a result and the output register is full
// and stalled; a bubble in the last stage is dropped behind a stalled output.
module piecewise_linear_depth_mapper_top
    import pldm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   operation,
    input  logic [CNT_W-1:0]       pivot_index,
    input  logic [DEPTH_W-1:0]     pivot_value,
    input  logic [DEPTH_W-1:0]     sample,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [SAMPLE_BITS-1:0] mapped_sample
);

    logic [DEPTH_W-1:0]     min_reg;
    logic [DEPTH_W-1:0]     max_reg;
    logic [CNT_W-1:0]       pieces_reg;
    logic                   lowq_reg;
    logic [N_W-1:0]         n_eff;
    cfg_t                   cfg;

    logic                   adv;
    logic                   out_free;
    find_t                  pf_beat;
    logic                   ram_we;
    logic [PIV_AW-1:0]      raddr0;
    logic [PIV_AW-1:0]      raddr1;
    logic [DEPTH_W-1:0]     rd0;
    logic [DEPTH_W-1:0]     rd1;
    logic                   fv_reg;
    logic [DEPTH_W-1:0]     fs_reg;
    logic [KD_W-1:0]        fkd_reg;
    fetch_t                 fetch_beat;
    lin_t                   lin_beat;
    logic                   res_valid;
    logic [SAMPLE_BITS-1:0] res_data;
    logic                   out_valid_reg;
    logic [SAMPLE_BITS-1:0] mapped_sample_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg    <= '0;
            max_reg    <= '1;
            pieces_reg <= CNT_W'(1);
            lowq_reg   <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_MIN_DEPTH:   min_reg    <= cfg_data[DEPTH_W-1:0];
                CFG_MAX_DEPTH:   max_reg    <= cfg_data[DEPTH_W-1:0];
                CFG_PIECE_COUNT: pieces_reg <= cfg_data[CNT_W-1:0];
                CFG_LOW_QUALITY: lowq_reg   <= cfg_data[0];
            endcase
        end
    end

    always_comb
    begin
        priority if (pieces_reg == '0)
        begin
            n_eff = N_W'(1);
        end
        else if (pieces_reg > CNT_W'(MAX_PIECES))
        begin
            n_eff = N_W'(MAX_PIECES);
        end
        else
        begin
            n_eff = N_W'(pieces_reg);
        end
        cfg.lo          = min_reg;
        cfg.d           = max_reg - min_reg;
        cfg.n           = n_eff;
        cfg.span_bad    = (max_reg <= min_reg);
        cfg.low_quality = lowq_reg;
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign adv      = out_free || !res_valid;
    assign in_stall = !adv;

    pldm_piece_find u_find (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .cfg      (cfg),
        .in_valid (in_valid),
        .in_op    (op_t'(operation)),
        .in_idx   (pivot_index),
        .in_val   (pivot_value),
        .in_s     (sample),
        .out_beat (pf_beat)
    );

    assign ram_we = adv && pf_beat.valid && (pf_beat.op == OP_PIVOT)
                    && (pf_beat.idx <= CNT_W'(MAX_PIECES));
    assign raddr0 = PIV_AW'(pf_beat.k);
    assign raddr1 = PIV_AW'(pf_beat.k) + PIV_AW'(1);

    pldm_ram #(
        .WIDTH (DEPTH_W),
        .DEPTH (PIV_DEPTH)
    ) u_piv_lo (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pf_beat.idx[PIV_AW-1:0]),
        .wdata (pf_beat.val),
        .re    (adv),
        .raddr (raddr0),
        .rdata (rd0)
    );

    pldm_ram #(
        .WIDTH (DEPTH_W),
        .DEPTH (PIV_DEPTH)
    ) u_piv_hi (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pf_beat.idx[PIV_AW-1:0]),
        .wdata (pf_beat.val),
        .re    (adv),
        .raddr (raddr1),
        .rdata (rd1)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= 1'b0;
        end
        else if (adv)
        begin
            fv_reg  <= pf_beat.valid && (pf_beat.op == OP_MAP);
            fs_reg  <= pf_beat.s;
            fkd_reg <= KD_W'(pf_beat.k) * KD_W'(cfg.d);
        end
    end

    assign fetch_beat = '{valid: fv_reg, s: fs_reg, kd: fkd_reg, p0: rd0, p1: rd1};

    pldm_interp u_interp (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .cfg      (cfg),
        .in_beat  (fetch_beat),
        .out_beat (lin_beat)
    );

    pldm_scale_div u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .cfg       (cfg),
        .in_beat   (lin_beat),
        .res_valid (res_valid),
        .res_data  (res_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg     <= res_valid;
            mapped_sample_reg <= res_data;
        end
    end

    assign out_valid     = out_valid_reg;
    assign mapped_sample = mapped_sample_reg;

`ifndef SYNTHESIS
    a_lowq_half: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && lowq_reg |-> !mapped_sample_reg[SAMPLE_BITS-1])
        else $error("low quality beat uses the top output bit");

    a_span_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (max_reg <= min_reg) |-> (mapped_sample_reg == '0))
        else $error("empty span beat is not zero");

    a_piece_range: assert property (@(posedge clk) disable iff (!rst_n)
        pf_beat.valid && (pf_beat.op == OP_MAP) |-> (N_W'(pf_beat.k) < cfg.n))
        else $error("piece index beyond piece count");
`endif

endmodule

[sim/tb_piecewise_linear_depth_mapper_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for piecewise_linear_depth_mapper_top: pivot writes, mapped samples,
// register settings, random gaps and output stalls. Depends on pldm_pkg and the top level.
module tb_piecewise_linear_depth_mapper_top;
    import pldm_pkg::*;

    class depth_map_scoreboard;
        logic [DEPTH_W-1:0]     lo_depth = 0;
        logic [DEPTH_W-1:0]     hi_depth = 16'hFFFF;
        logic [CNT_W-1:0]       pieces = 1;
        logic                   halve = 0;
        logic [DEPTH_W-1:0]     pivots [PIV_DEPTH];
        logic [SAMPLE_BITS-1:0] pending_maps [$];
        int                     mismatches = 0;

        function logic [SAMPLE_BITS-1:0] map_depth(logic [DEPTH_W-1:0] s);
            longint m, lo, d, n, x, k, start, p0, dp, num, den, q;
            m  = (longint'(1) << SAMPLE_BITS) - 1;
            lo = longint'(lo_depth);
            d  = longint'(hi_depth) - lo;
            n  = longint'(pieces);
            if (d <= 0)
                return 0;
            if (n < 1)
                n = 1;
            if (n > MAX_PIECES)
                n = MAX_PIECES;
            x = (longint'(s) - lo) * n;
            k = (x < 0) ? 0 : x / d;
            if (k > n - 1)
                k = n - 1;
            start = lo + (k * d) / n;
            p0    = longint'(pivots[k]);
            dp    = longint'(pivots[k + 1]) - p0;
            num   = (2 * (longint'(s) - start) * dp * n + 2 * d * (p0 - lo) + d) * m;
            den   = 2 * d * d;
            if (num < 0)
                return 0;
            q = num / den;
            if (q > m)
                q = m;
            if (halve)
                q = q >> 1;
            return q[SAMPLE_BITS-1:0];
        endfunction

        function void note_beat(op_t op, logic [CNT_W-1:0] idx, logic [DEPTH_W-1:0] val,
                                logic [DEPTH_W-1:0] s);
            if (op == OP_PIVOT)
            begin
                if (idx <= MAX_PIECES)
                    pivots[idx] = val;
            end
            else
                pending_maps.push_back(map_depth(s));
        endfunction

        function void check_result(logic [SAMPLE_BITS-1:0] got);
            logic [SAMPLE_BITS-1:0] want;
            if (pending_maps.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected mapped_sample %0d", got);
                return;
            end
            want = pending_maps.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mapped_sample mismatch: expected %0d, got %0d", want, got);
            end
        endfunction
    endclass

    logic                   clk = 0;
    logic                   rst_n = 0;
    logic                   cfg_write = 0;
    logic [CFG_IDX_W-1:0]   cfg_index = CFG_MIN_DEPTH;
    logic [CFG_W-1:0]       cfg_data = 0;
    logic                   in_valid = 0;
    logic                   in_stall;
    logic                   operation = OP_MAP;
    logic [CNT_W-1:0]       pivot_index = 0;
    logic [DEPTH_W-1:0]     pivot_value = 0;
    logic [DEPTH_W-1:0]     sample = 0;
    logic                   out_valid;
    logic                   out_stall = 0;
    logic [SAMPLE_BITS-1:0] mapped_sample;

    depth_map_scoreboard maps = new();
    bit                  steady_in = 0;
    bit                  steady_out = 0;

    piecewise_linear_depth_mapper_top uut (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            maps.note_beat(op_t'(operation), pivot_index, pivot_value, sample);
        if (rst_n && out_valid && !out_stall)
            maps.check_result(mapped_sample);
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_beat(op_t op, logic [CNT_W-1:0] idx, logic [DEPTH_W-1:0] val,
                             logic [DEPTH_W-1:0] s);
        int gap;
        gap = steady_in ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid = 0;
            repeat (gap) @(negedge clk);
        end
        in_valid    = 1;
        operation   = op;
        pivot_index = idx;
        pivot_value = val;
        sample      = s;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_W-1:0] data);
        in_valid  = 0;
        cfg_write = 1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_write = 0;
        case (idx)
            CFG_MIN_DEPTH:   maps.lo_depth = data;
            CFG_MAX_DEPTH:   maps.hi_depth = data;
            CFG_PIECE_COUNT: maps.pieces = data[CNT_W-1:0];
            default:         maps.halve = data[0];
        endcase
    endtask

    task automatic drain();
        in_valid = 0;
        while (maps.pending_maps.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic set_mode(int lo, int hi, int n, int lq);
        drain();
        write_reg(CFG_MIN_DEPTH, CFG_W'(lo));
        write_reg(CFG_MAX_DEPTH, CFG_W'(hi));
        write_reg(CFG_PIECE_COUNT, CFG_W'(n));
        write_reg(CFG_LOW_QUALITY, CFG_W'(lq));
    endtask

    task automatic random_beats(int count);
        logic [DEPTH_W-1:0] s;
        for (int i = 0; i < count; i++)
        begin
            if (i % 100 == 0)
                steady_in = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 99) < 12)
                send_beat(OP_PIVOT, CNT_W'($urandom_range(0, 63)),
                          DEPTH_W'($urandom_range(0, 65535)), DEPTH_W'($urandom));
            else
            begin
                if (maps.lo_depth < maps.hi_depth && $urandom_range(0, 3) != 0)
                    s = DEPTH_W'($urandom_range(maps.lo_depth, maps.hi_depth));
                else
                    s = DEPTH_W'($urandom_range(0, 65535));
                send_beat(OP_MAP, CNT_W'($urandom_range(0, 63)), DEPTH_W'($urandom), s);
            end
        end
    endtask

    initial
    begin
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 499) == 0)
                steady_out = ~steady_out;
            if (steady_out)
                out_stall = 0;
            else if ($urandom_range(0, 99) < 25)
            begin
                out_stall = 1;
                repeat (pick_gap()) @(negedge clk);
            end
            else
                out_stall = 0;
        end
    end

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n = 1;
        @(negedge clk);
        for (int i = 0; i <= MAX_PIECES; i++)
            send_beat(OP_PIVOT, CNT_W'(i), (i % 2) ? 16'hFFFF : 16'h0000, 0);
        send_beat(OP_PIVOT, 6'd63, 16'h1234, 0);
        send_beat(OP_PIVOT, 6'd33, 16'h5678, 0);
        send_beat(OP_MAP, 0, 0, 16'h0000);
        send_beat(OP_MAP, 0, 0, 16'hFFFF);
        send_beat(OP_MAP, 0, 0, 16'h8000);
        set_mode(0, 65535, 32, 0);
        send_beat(OP_MAP, 0, 0, 16'h0000);
        send_beat(OP_MAP, 0, 0, 16'hFFFF);
        send_beat(OP_MAP, 0, 0, 16'h07FF);
        random_beats(220);
        set_mode(1000, 5000, 7, 1);
        send_beat(OP_MAP, 0, 0, 16'd999);
        send_beat(OP_MAP, 0, 0, 16'd5001);
        random_beats(220);
        set_mode(5000, 5000, 4, 0);
        random_beats(60);
        set_mode(6000, 100, 3, 0);
        random_beats(60);
        set_mode(0, 65535, 0, 1);
        random_beats(220);
        set_mode(100, 60000, 63, 0);
        random_beats(260);
        set_mode(65534, 65535, 32, 0);
        random_beats(120);
        set_mode(12345, 23456, 17, 0);
        random_beats(260);
        set_mode(0, 1, 2, 1);
        random_beats(120);
        set_mode(300, 40000, 33, 0);
        random_beats(200);
        drain();
        if (maps.mismatches == 0 && maps.pending_maps.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

endmodule
